// ----- rtl/core/mtbc_pkg.sv -----
// shared types and constants of the multi-type bracket checker
`default_nettype none
package mtbc_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int KIND_WIDTH  = 16;
	localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

	typedef logic [KIND_WIDTH-1:0] kind_t;
	typedef logic [LEVEL_W-1:0]    level_t;

	// shift command for the stack cells
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

	typedef struct packed {
		logic balanced;
		logic overflowed;
	} verdict_t;

endpackage
`default_nettype wire

// ----- rtl/core/mtbc_if.sv -----
// valid/ready channel interfaces for tokens and verdicts
`default_nettype none
interface mtbc_token_if;
	logic        valid;
	logic        ready;
	logic [15:0] kind;
	logic        is_close;
	logic        first_token;
	logic        last_token;

	modport source (output valid, kind, is_close, first_token, last_token, input ready);
	modport sink   (input valid, kind, is_close, first_token, last_token, output ready);
endinterface

interface mtbc_verdict_if;
	logic valid;
	logic ready;
	logic balanced;
	logic overflowed;

	modport source (output valid, balanced, overflowed, input ready);
	modport sink   (input valid, balanced, overflowed, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mtbc_cell.sv -----
// one stack entry: shifts down on push, up on pop
`default_nettype none
module mtbc_cell (
	input  wire                 clk,
	input  mtbc_pkg::cell_ctl_t ctl,
	input  mtbc_pkg::kind_t     from_up,
	input  mtbc_pkg::kind_t     from_down,
	output mtbc_pkg::kind_t     value
);
	import mtbc_pkg::*;

	kind_t value_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			value_q <= from_up;
		end else if (ctl.pop) begin
			value_q <= from_down;
		end
	end

	assign value = value_q;
endmodule
`default_nettype wire

// ----- rtl/core/mtbc_out_buf.sv -----
// verdict output register with one skid entry
`default_nettype none
module mtbc_out_buf (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  mtbc_pkg::verdict_t data,
	output logic               full,
	mtbc_verdict_if.source     res
);
	import mtbc_pkg::*;

	logic     out_valid_q;
	verdict_t out_data_q;
	logic     skid_valid_q;
	verdict_t skid_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res.ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res.ready || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : data;
		end else if (push) begin
			skid_data_q <= data;
		end
	end

	assign full           = skid_valid_q;
	assign res.valid      = out_valid_q;
	assign res.balanced   = out_data_q.balanced;
	assign res.overflowed = out_data_q.overflowed;
endmodule
`default_nettype wire

// ----- rtl/core/multi_type_bracket_checker_top.sv -----
// multi-type bracket checker: shift-register stack of cells plus verdict buffer
//
//   channel  dir  fields                                   handshake
//   tok      in   kind, is_close, first_token, last_token   valid/ready
//   res      out  balanced, overflowed                      valid/ready
//
// one token per cycle while tok.ready is high; push, pop and top compare all happen at cell 0 of the chain
// a verdict is registered in the output stage, or in its skid entry while res is stalled
// reset clears the level counter and marks; stack cells hold no reset value
// tok.ready drops only while the skid entry holds a verdict behind a stalled res
`default_nettype none
module multi_type_bracket_checker_top (
	input  wire            clk,
	input  wire            arst_n,
	mtbc_token_if.sink     tok,
	mtbc_verdict_if.source res
);
	import mtbc_pkg::*;

	level_t    level_q;
	logic      fail_q;
	logic      ovf_q;
	logic      skid_full;
	kind_t     cell_val [STACK_DEPTH];
	cell_ctl_t cell_ctl;

	logic     accept;
	kind_t    tok_kind;
	level_t   lvl_eff;
	logic     fail_eff;
	logic     ovf_eff;
	logic     active;
	logic     is_full;
	logic     is_empty;
	logic     top_match;
	logic     push_ok;
	logic     pop_ok;
	logic     fail_set;
	logic     ovf_set;
	level_t   lvl_after;
	verdict_t verdict;

	assign tok.ready = !skid_full;
	assign accept    = tok.valid && tok.ready;
	assign tok_kind  = tok.kind[KIND_WIDTH-1:0];

	// a first token starts from an empty stack
	assign lvl_eff  = tok.first_token ? '0 : level_q;
	assign fail_eff = tok.first_token ? 1'b0 : fail_q;
	assign ovf_eff  = tok.first_token ? 1'b0 : ovf_q;
	assign active   = !fail_eff && !ovf_eff;

	assign is_full   = (lvl_eff == LEVEL_W'(STACK_DEPTH));
	assign is_empty  = (lvl_eff == '0);
	assign top_match = (cell_val[0] == tok_kind);

	assign push_ok  = active && !tok.is_close && !is_full;
	assign ovf_set  = active && !tok.is_close && is_full;
	assign pop_ok   = active && tok.is_close && !is_empty && top_match;
	assign fail_set = active && tok.is_close && (is_empty || !top_match);

	always_comb begin
		lvl_after = lvl_eff;
		if (push_ok) begin
			lvl_after = lvl_eff + LEVEL_W'(1);
		end else if (pop_ok) begin
			lvl_after = lvl_eff - LEVEL_W'(1);
		end
	end

	assign verdict.balanced   = !(fail_eff || fail_set) && !(ovf_eff || ovf_set)
		&& (lvl_after == '0);
	assign verdict.overflowed = ovf_eff || ovf_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			fail_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (tok.last_token) begin
				level_q <= '0;
				fail_q  <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				level_q <= lvl_after;
				fail_q  <= fail_eff || fail_set;
				ovf_q   <= ovf_eff || ovf_set;
			end
		end
	end

	assign cell_ctl.push = accept && push_ok;
	assign cell_ctl.pop  = accept && pop_ok;

	// cell 0 is the top of stack; entries move deeper on push
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		kind_t up_val;
		kind_t down_val;
		if (i == 0) begin : g_head
			assign up_val = tok_kind;
		end else begin : g_body
			assign up_val = cell_val[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_tail
			assign down_val = cell_val[i];
		end else begin : g_inner
			assign down_val = cell_val[i+1];
		end
		mtbc_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.from_up   (up_val),
			.from_down (down_val),
			.value     (cell_val[i])
		);
	end

	mtbc_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && tok.last_token),
		.data   (verdict),
		.full   (skid_full),
		.res    (res)
	);

`ifndef SYNTH
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LEVEL_W'(STACK_DEPTH))
		else $error("stack level beyond depth");

	a_verdict_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tok.last_token |=> res.valid)
		else $error("no verdict after last token");

	a_seq_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tok.last_token |=> (level_q == '0) && !fail_q && !ovf_q)
		else $error("sequence state not cleared after verdict");

	a_no_shift_when_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(fail_q || ovf_q) && !tok.first_token |-> !cell_ctl.push && !cell_ctl.pop)
		else $error("stack moved in a failed sequence");
`endif
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for the multi-type bracket checker
`default_nettype none
module testbench;
	import mtbc_pkg::*;

	typedef struct packed {
		kind_t kind;
		logic  is_close;
	} token_t;

	// ways a well-formed sequence gets broken
	typedef enum int {
		FLIP_KIND,
		DROP_TOKEN,
		EXTRA_CLOSE,
		FLIP_DIR
	} damage_t;

	logic clk;
	logic arst_n;

	mtbc_token_if   tok_ch ();
	mtbc_verdict_if res_ch ();

	multi_type_bracket_checker_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok_ch),
		.res    (res_ch)
	);

	// shadow copy of the sequence state
	kind_t    shadow_stack [STACK_DEPTH];
	int       shadow_level = 0;
	bit       shadow_failed = 1'b0;
	bit       shadow_over = 1'b0;
	verdict_t pending_verdicts [$];

	token_t seq_toks [$];
	int     tokens_sent = 0;
	int     errors = 0;
	bit     idle_on = 1'b0;
	bit     rx_idle_on = 1'b0;
	int     rx_hold_cycles = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void start_sequence();
		shadow_level  = 0;
		shadow_failed = 1'b0;
		shadow_over   = 1'b0;
	endfunction

	// update the shadow state with one accepted token, queue a verdict on the last one
	function automatic void apply_token(kind_t kind, bit is_close, bit first_tk, bit last_tk);
		verdict_t v;
		if (first_tk)
			start_sequence();
		if (!shadow_failed && !shadow_over) begin
			if (!is_close) begin
				if (shadow_level >= STACK_DEPTH) begin
					shadow_over = 1'b1;
				end else begin
					shadow_stack[shadow_level] = kind;
					shadow_level++;
				end
			end else if (shadow_level == 0 || shadow_stack[shadow_level-1] != kind) begin
				shadow_failed = 1'b1;
			end else begin
				shadow_level--;
			end
		end
		if (last_tk) begin
			v.balanced   = !shadow_failed && !shadow_over && shadow_level == 0;
			v.overflowed = shadow_over;
			pending_verdicts = {pending_verdicts, v};
			start_sequence();
		end
	endfunction

	// mostly short pauses, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_token(kind_t kind, bit is_close, bit first_tk, bit last_tk);
		int gap;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			tok_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tok_ch.valid       <= 1'b1;
		tok_ch.kind        <= kind;
		tok_ch.is_close    <= is_close;
		tok_ch.first_token <= first_tk;
		tok_ch.last_token  <= last_tk;
		@(posedge clk);
		while (!tok_ch.ready)
			@(posedge clk);
		apply_token(kind, is_close, first_tk, last_tk);
		tokens_sent++;
	endtask

	task automatic send_seq(bit mark_first);
		foreach (seq_toks[i])
			send_token(seq_toks[i].kind, seq_toks[i].is_close, mark_first && i == 0,
				i == seq_toks.size() - 1);
	endtask

	// sender stops until every verdict is back
	task automatic wait_drained();
		tok_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic build_balanced(int pairs, bit narrow);
		kind_t  open_kinds [$];
		int     opened;
		token_t t;
		opened = 0;
		seq_toks.delete();
		while (opened < pairs || open_kinds.size() != 0) begin
			if (opened < pairs && (open_kinds.size() == 0 || $urandom_range(0, 1) == 1)) begin
				t.kind     = narrow ? kind_t'($urandom_range(1, 4)) : kind_t'($urandom);
				t.is_close = 1'b0;
				open_kinds = {open_kinds, t.kind};
				opened++;
			end else begin
				t.kind     = open_kinds[$];
				t.is_close = 1'b1;
				open_kinds.delete(open_kinds.size() - 1);
			end
			seq_toks = {seq_toks, t};
		end
	endtask

	task automatic test_directed();
		idle_on    = 1'b1;
		rx_idle_on = 1'b1;
		send_token(16'hFFFF, 1'b0, 1'b1, 1'b1);
		// close on an empty stack
		send_token(16'h0001, 1'b1, 1'b1, 1'b1);
		send_token(16'h0001, 1'b0, 1'b1, 1'b0);
		send_token(16'h0001, 1'b1, 1'b0, 1'b1);
		// kind zero is just another kind
		send_token(16'h0000, 1'b0, 1'b1, 1'b0);
		send_token(16'h0000, 1'b1, 1'b0, 1'b1);
		send_token(16'h0001, 1'b0, 1'b1, 1'b0);
		send_token(16'hFFFF, 1'b0, 1'b0, 1'b0);
		send_token(16'hFFFF, 1'b1, 1'b0, 1'b0);
		send_token(16'h0001, 1'b1, 1'b0, 1'b1);
		send_token(16'h8000, 1'b0, 1'b1, 1'b0);
		send_token(16'h7FFF, 1'b1, 1'b0, 1'b1);
		// fail mark sticks even when later tokens would balance
		send_token(16'h0005, 1'b0, 1'b1, 1'b0);
		send_token(16'h0006, 1'b1, 1'b0, 1'b0);
		send_token(16'h0006, 1'b0, 1'b0, 1'b0);
		send_token(16'h0006, 1'b1, 1'b0, 1'b1);
		// no first_token: the previous verdict already cleared the state
		send_token(16'h0002, 1'b0, 1'b0, 1'b0);
		send_token(16'h0002, 1'b1, 1'b0, 1'b1);
		// restart in the middle of an open sequence
		send_token(16'h0007, 1'b0, 1'b1, 1'b0);
		send_token(16'h0008, 1'b0, 1'b0, 1'b0);
		send_token(16'h0009, 1'b0, 1'b1, 1'b0);
		send_token(16'h0009, 1'b1, 1'b0, 1'b1);
		wait_drained();
	endtask

	// verdict side stalls long while tokens keep coming
	task automatic test_backpressure();
		idle_on    = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_cycles = 80;
		for (int i = 0; i < 20; i++) begin
			send_token(kind_t'($urandom), 1'b0, 1'b1, 1'b0);
			send_token(tok_ch.kind, i[0], 1'b0, 1'b1);
		end
		wait_drained();
	endtask

	task automatic test_random();
		int      target;
		int      pairs;
		int      len;
		int      idx;
		int      pick;
		token_t  t;
		target = 800;
		while (tokens_sent < target) begin
			idle_on    = $urandom_range(0, 4) != 0;
			rx_idle_on = $urandom_range(0, 4) != 0;
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				pick  = $urandom_range(0, 99);
				pairs = pick < 70 ? $urandom_range(1, 6) :
					pick < 96 ? $urandom_range(7, 30) : $urandom_range(31, 200);
				build_balanced(pairs, 1'($urandom_range(0, 1)));
				// a quarter of the sequences get broken on purpose
				if ($urandom_range(0, 3) == 0) begin
					idx = $urandom_range(0, seq_toks.size() - 1);
					case (damage_t'($urandom_range(0, 3)))
						FLIP_KIND: seq_toks[idx].kind ^= kind_t'($urandom_range(1, 65535));
						DROP_TOKEN: seq_toks.delete(idx);
						EXTRA_CLOSE: begin
							t.kind     = kind_t'($urandom_range(1, 4));
							t.is_close = 1'b1;
							seq_toks.insert(idx, t);
						end
						FLIP_DIR: seq_toks[idx].is_close = ~seq_toks[idx].is_close;
						default: ;
					endcase
				end
				send_seq($urandom_range(0, 4) != 0);
			end else begin
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++)
					send_token(kind_t'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 4)),
						1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
						i == len - 1 ? 1'($urandom_range(0, 1)) : $urandom_range(0, 9) == 0);
			end
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	// verdict receiver
	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				res_ch.ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("verdict with none pending: balanced=%0b overflowed=%0b",
					res_ch.balanced, res_ch.overflowed);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (res_ch.balanced !== want.balanced) begin
					$error("balanced: expected %0b, got %0b", want.balanced, res_ch.balanced);
					errors++;
				end
				if (res_ch.overflowed !== want.overflowed) begin
					$error("overflowed: expected %0b, got %0b", want.overflowed,
						res_ch.overflowed);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n             <= 1'b0;
		tok_ch.valid       <= 1'b0;
		tok_ch.kind        <= '0;
		tok_ch.is_close    <= 1'b0;
		tok_ch.first_token <= 1'b0;
		tok_ch.last_token  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#10000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
